// File: rtl/core/whf_pkg.sv
package whf_pkg;

	// Widths fixed by the register map and the result format
	localparam int FRAC_BITS  = 4;
	localparam int PEAK_W     = 16;
	localparam int CNT_W      = 8;
	localparam int THR_W      = 12;
	localparam int BASE_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// Default sizes handed to the top level
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int AREA_BITS_DEF   = 28;

	localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
	localparam logic [PEAK_W-1:0] PEAK_MAX  = '1;

	// Register reset values
	localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(3);
	localparam logic [CNT_W-1:0]  MIN_RUN_RST   = CNT_W'(3);
	localparam logic [BASE_W-1:0] BASELINE_RST  = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_MIN_RUN   = 2'd1,
		REG_BASELINE  = 2'd2,
		REG_INVERT    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [THR_W-1:0]  threshold;
		logic [CNT_W-1:0]  min_run;
		logic [BASE_W-1:0] baseline;
		logic              invert_polarity;
	} whf_cfg_t;

endpackage

// File: rtl/core/whf_ifs.sv
interface whf_in_if import whf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   kept;
	logic                   first;

	modport source (output valid, sample, kept, first, input ready);
	modport sink   (input valid, sample, kept, first, output ready);
endinterface

interface whf_out_if import whf_pkg::*; #(
	parameter int AREA_BITS = AREA_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [AREA_BITS-1:0] total_area;
	logic [PEAK_W-1:0]    total_peak;
	logic [AREA_BITS-1:0] kept_area;
	logic [PEAK_W-1:0]    kept_peak;

	modport source (output valid, total_area, total_peak, kept_area, kept_peak, input ready);
	modport sink   (input valid, total_area, total_peak, kept_area, kept_peak, output ready);
endinterface

// File: rtl/core/whf_cfg_regs.sv
module whf_cfg_regs import whf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output whf_cfg_t              cfg
);

	// Decode the index and load the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.threshold       <= THRESHOLD_RST;
			cfg.min_run         <= MIN_RUN_RST;
			cfg.baseline        <= BASELINE_RST;
			cfg.invert_polarity <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD: cfg.threshold       <= cfg_data[THR_W-1:0];
				REG_MIN_RUN:   cfg.min_run         <= cfg_data[CNT_W-1:0];
				REG_BASELINE:  cfg.baseline        <= cfg_data[BASE_W-1:0];
				REG_INVERT:    cfg.invert_polarity <= cfg_data[0];
			endcase
		end
	end

endmodule

// File: rtl/core/whf_run_acc.sv
module whf_run_acc import whf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int AREA_BITS   = AREA_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  whf_cfg_t               cfg,
	input  logic                   step,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   kept,
	input  logic                   first,
	output logic                   emit,
	output logic [AREA_BITS-1:0]   total_area,
	output logic [PEAK_W-1:0]      total_peak,
	output logic [AREA_BITS-1:0]   kept_area,
	output logic [PEAK_W-1:0]      kept_peak
);

	localparam int SMP_W = SAMPLE_BITS + FRAC_BITS;
	localparam int DEV_W = (SMP_W > BASE_W) ? SMP_W : BASE_W;
	localparam int SUM_W = ((AREA_BITS > DEV_W) ? AREA_BITS : DEV_W) + 1;
	localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

	logic                 active_q;
	logic [CNT_W-1:0]     run_count_q;
	logic [AREA_BITS-1:0] area_q;
	logic [PEAK_W-1:0]    peak_q;
	logic [AREA_BITS-1:0] kept_area_q;
	logic [PEAK_W-1:0]    kept_peak_q;

	logic                 active_b;
	logic [CNT_W-1:0]     run_count_b;
	logic [AREA_BITS-1:0] area_b;
	logic [PEAK_W-1:0]    peak_b;
	logic [AREA_BITS-1:0] kept_area_b;
	logic [PEAK_W-1:0]    kept_peak_b;

	logic [DEV_W-1:0]     smp_x;
	logic [DEV_W-1:0]     base_x;
	logic [DEV_W-1:0]     thr_x;
	logic [DEV_W-1:0]     dev;
	logic                 over;
	logic                 pass;
	logic [PEAK_W-1:0]    pk;
	logic [SUM_W-1:0]     area_sum;
	logic [SUM_W-1:0]     kept_sum;
	logic [AREA_BITS-1:0] area_sat;
	logic [AREA_BITS-1:0] kept_sat;
	logic                 close;

	// Start of a waveform sees a cleared run
	always_comb begin
		active_b    = first ? 1'b0 : active_q;
		run_count_b = first ? '0   : run_count_q;
		area_b      = first ? '0   : area_q;
		peak_b      = first ? '0   : peak_q;
		kept_area_b = first ? '0   : kept_area_q;
		kept_peak_b = first ? '0   : kept_peak_q;
	end

	// Deviation from baseline in the chosen polarity, in sixteenths
	always_comb begin
		smp_x  = DEV_W'({sample, {FRAC_BITS{1'b0}}});
		base_x = DEV_W'(cfg.baseline);
		thr_x  = DEV_W'({cfg.threshold, {FRAC_BITS{1'b0}}});
		if (cfg.invert_polarity) begin
			over = base_x > smp_x;
			dev  = base_x - smp_x;
		end else begin
			over = smp_x > base_x;
			dev  = smp_x - base_x;
		end
		pass = over && (dev > thr_x);
		pk   = (dev > DEV_W'(PEAK_MAX)) ? PEAK_MAX : dev[PEAK_W-1:0];
	end

	// Saturating area sums
	always_comb begin
		area_sum = SUM_W'(area_b) + SUM_W'(dev);
		kept_sum = SUM_W'(kept_area_b) + SUM_W'(dev);
		area_sat = (area_sum > SUM_W'(AREA_MAX)) ? AREA_MAX : area_sum[AREA_BITS-1:0];
		kept_sat = (kept_sum > SUM_W'(AREA_MAX)) ? AREA_MAX : kept_sum[AREA_BITS-1:0];
	end

	// A failing sample closes a run that is long enough
	assign close      = !pass && active_b && (run_count_b > cfg.min_run);
	assign emit       = close && (area_b != '0);
	assign total_area = area_b;
	assign total_peak = peak_b;
	assign kept_area  = kept_area_b;
	assign kept_peak  = kept_peak_b;

	// Advance the run state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			run_count_q <= '0;
			area_q      <= '0;
			peak_q      <= '0;
			kept_area_q <= '0;
			kept_peak_q <= '0;
		end else if (step) begin
			if (pass) begin
				active_q    <= 1'b1;
				run_count_q <= (run_count_b == COUNT_MAX) ? COUNT_MAX : run_count_b + 1'b1;
				area_q      <= area_sat;
				kept_area_q <= kept ? kept_sat : kept_area_b;
				peak_q      <= (pk > peak_b) ? pk : peak_b;
				kept_peak_q <= ((pk > peak_b) && kept) ? pk : kept_peak_b;
			end else if (close) begin
				active_q    <= 1'b0;
				run_count_q <= '0;
				area_q      <= '0;
				peak_q      <= '0;
				kept_area_q <= '0;
				kept_peak_q <= '0;
			end else begin
				active_q    <= active_b;
				run_count_q <= run_count_b;
				area_q      <= area_b;
				peak_q      <= peak_b;
				kept_area_q <= kept_area_b;
				kept_peak_q <= kept_peak_b;
			end
		end
	end

	// Kept sums are a subset of the totals
	a_kept_area_le: assert property (@(posedge clk) disable iff (!arst_n)
		kept_area_q <= area_q)
		else $error("kept area exceeds total area");

	a_kept_peak_le: assert property (@(posedge clk) disable iff (!arst_n)
		kept_peak_q <= peak_q)
		else $error("kept peak exceeds total peak");

	// An idle run holds nothing
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (run_count_q == '0 && area_q == '0 && peak_q == '0))
		else $error("inactive run holds accumulated state");

	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (run_count_q != '0))
		else $error("active run with zero count");

endmodule

// File: rtl/core/waveform_hit_finder_unit.sv
// Threshold hit finder over a stream of ADC samples.
// Input channel (samples): one item per ADC sample with a kept flag and a
// first flag that clears all run state at the start of a waveform.
// Output channel (hits): one item per closed run long enough to report,
// carrying total and kept-only area and peak in sixteenths of a count.
// Configuration: cfg_we/cfg_index/cfg_data write threshold, min_run,
// baseline and polarity; write only while no item is in flight.
// The result of a closing sample passes through the input register, then
// the result register, before it is valid on hits. Throughput: one item
// per cycle unless an item's result must wait for the output register;
// the per-sample update is a threshold compare and two saturating adds on
// the run accumulators, all combinational.
// Reset: registers return to threshold 3, min_run 3, baseline 0, positive
// polarity; the run state and both pipeline stages clear.
// Stall: while a result waits in the output register the input register
// still drains items that produce no result; an item that would produce a
// result holds in the input register, with samples.ready low, until the
// output register is taken.
module waveform_hit_finder_unit import whf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int AREA_BITS   = AREA_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	whf_in_if.sink                samples,
	whf_out_if.source             hits
);

	whf_cfg_t cfg;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   kept_s1;
	logic                   first_s1;

	logic                   out_valid_q;
	logic [AREA_BITS-1:0]   total_area_q;
	logic [PEAK_W-1:0]      total_peak_q;
	logic [AREA_BITS-1:0]   kept_area_q;
	logic [PEAK_W-1:0]      kept_peak_q;

	logic                   emit;
	logic [AREA_BITS-1:0]   res_area;
	logic [PEAK_W-1:0]      res_peak;
	logic [AREA_BITS-1:0]   res_kept_area;
	logic [PEAK_W-1:0]      res_kept_peak;
	logic                   out_free;
	logic                   step;

	whf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	whf_run_acc #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.AREA_BITS   (AREA_BITS)
	) u_run (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step       (step),
		.sample     (sample_s1),
		.kept       (kept_s1),
		.first      (first_s1),
		.emit       (emit),
		.total_area (res_area),
		.total_peak (res_peak),
		.kept_area  (res_kept_area),
		.kept_peak  (res_kept_peak)
	);

	// Advance the held item unless its result has nowhere to go
	assign out_free      = !out_valid_q || hits.ready;
	assign step          = valid_s1 && (out_free || !emit);
	assign samples.ready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			sample_s1 <= samples.sample;
			kept_s1   <= samples.kept;
			first_s1  <= samples.first;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (hits.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			total_area_q <= res_area;
			total_peak_q <= res_peak;
			kept_area_q  <= res_kept_area;
			kept_peak_q  <= res_kept_peak;
		end
	end

	assign hits.valid      = out_valid_q;
	assign hits.total_area = total_area_q;
	assign hits.total_peak = total_peak_q;
	assign hits.kept_area  = kept_area_q;
	assign hits.kept_peak  = kept_peak_q;

	// A result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hits.ready) |-> !(step && emit))
		else $error("pending result overwritten");

	// A held item that can advance always does
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_free) |-> step)
		else $error("input register stalled with free output");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top import whf_pkg::*;;

	localparam int SAMPLE_W       = SAMPLE_BITS_DEF;
	localparam int AREA_W         = AREA_BITS_DEF;
	localparam longint unsigned AREA_LIMIT = (64'd1 << AREA_W) - 1;
	localparam int SAMPLE_TOP     = (1 << SAMPLE_W) - 1;
	localparam int LONG_STALL     = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SAT_RUN_LEN    = 260;
	localparam int RANDOM_ITEMS   = 40;

	typedef struct packed {
		logic [AREA_W-1:0] total_area;
		logic [PEAK_W-1:0] total_peak;
		logic [AREA_W-1:0] kept_area;
		logic [PEAK_W-1:0] kept_peak;
	} hit_t;

	// How a directed row is checked: by the predictor, against a typed result, or with no hit expected
	typedef enum logic [1:0] {
		CHK_PRED,
		CHK_NONE,
		CHK_HIT
	} chk_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                kept;
		logic                first;
		chk_t                how;
		hit_t                want;
	} dir_row_t;

	localparam hit_t NO_HIT = '0;

	// Directed rows, run under the reset register values
	// (threshold 3, min_run 3, baseline 0, positive polarity)
	localparam dir_row_t DIRECTED_ROWS [24] = '{
		'{12'd0,    1'b0, 1'b1, CHK_NONE, NO_HIT},
		'{12'd4095, 1'b1, 1'b0, CHK_NONE, NO_HIT},
		'{12'd4095, 1'b0, 1'b0, CHK_NONE, NO_HIT},
		'{12'd4,    1'b1, 1'b0, CHK_NONE, NO_HIT},
		'{12'd100,  1'b1, 1'b0, CHK_NONE, NO_HIT},
		'{12'd0,    1'b0, 1'b0, CHK_HIT,
			'{28'd132704, 16'd65520, 28'd67184, 16'd65520}},
		// exactly at threshold: does not pass
		'{12'd3,    1'b1, 1'b0, CHK_NONE, NO_HIT},
		// short run stays open across a failing sample
		'{12'd4,    1'b0, 1'b0, CHK_PRED, NO_HIT},
		'{12'd5,    1'b1, 1'b0, CHK_PRED, NO_HIT},
		'{12'd0,    1'b1, 1'b0, CHK_PRED, NO_HIT},
		'{12'd6,    1'b1, 1'b0, CHK_PRED, NO_HIT},
		'{12'd7,    1'b0, 1'b0, CHK_PRED, NO_HIT},
		'{12'd2,    1'b0, 1'b0, CHK_PRED, NO_HIT},
		// open run dropped by the next waveform start
		'{12'd50,   1'b1, 1'b0, CHK_PRED, NO_HIT},
		'{12'd60,   1'b1, 1'b0, CHK_PRED, NO_HIT},
		'{12'd70,   1'b1, 1'b0, CHK_PRED, NO_HIT},
		'{12'd80,   1'b1, 1'b0, CHK_PRED, NO_HIT},
		'{12'd90,   1'b1, 1'b1, CHK_PRED, NO_HIT},
		'{12'd0,    1'b0, 1'b0, CHK_PRED, NO_HIT},
		// full-scale run with nothing kept
		'{12'd4095, 1'b0, 1'b1, CHK_PRED, NO_HIT},
		'{12'd4095, 1'b0, 1'b0, CHK_PRED, NO_HIT},
		'{12'd4095, 1'b0, 1'b0, CHK_PRED, NO_HIT},
		'{12'd4095, 1'b0, 1'b0, CHK_PRED, NO_HIT},
		'{12'd1,    1'b0, 1'b0, CHK_HIT,
			'{28'd262080, 16'd65520, 28'd0, 16'd0}}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	whf_in_if  #(.SAMPLE_BITS(SAMPLE_W)) smp_if ();
	whf_out_if #(.AREA_BITS(AREA_W))     hit_if ();

	waveform_hit_finder_unit #(
		.SAMPLE_BITS(SAMPLE_W),
		.AREA_BITS(AREA_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.samples(smp_if),
		.hits(hit_if)
	);

	// Register copy and run state of the predictor
	whf_cfg_t        cfg_shadow = '{THRESHOLD_RST, MIN_RUN_RST, BASELINE_RST, 1'b0};
	logic            run_on = 1'b0;
	logic [CNT_W-1:0] run_len = '0;
	longint unsigned area_sum = 0;
	longint unsigned kept_sum = 0;
	longint unsigned peak_max = 0;
	longint unsigned kept_peak_max = 0;

	hit_t hits_due [$];

	int send_idle = 0;
	int recv_idle = 0;
	int mismatches = 0;
	int samples_sent = 0;
	int hits_seen = 0;
	int settings_used = 0;
	int idle_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void clear_run();
		run_on = 1'b0;
		run_len = '0;
		area_sum = 0;
		kept_sum = 0;
		peak_max = 0;
		kept_peak_max = 0;
	endfunction

	function automatic longint unsigned sat_area(longint unsigned acc, longint unsigned add);
		longint unsigned sum;
		sum = acc + add;
		return (sum > AREA_LIMIT) ? AREA_LIMIT : sum;
	endfunction

	// Advance the run state by one sample; queue the hit it closes, if any
	function automatic void track_run(logic [SAMPLE_W-1:0] s, logic k, logic f);
		longint unsigned scaled, base, thr, dev, pk;
		bit pass;
		hit_t h;
		scaled = s;
		scaled = scaled << FRAC_BITS;
		base = cfg_shadow.baseline;
		thr = cfg_shadow.threshold;
		thr = thr << FRAC_BITS;
		dev = 0;
		pass = 1'b0;
		if (f)
			clear_run();
		if (cfg_shadow.invert_polarity) begin
			if (base > scaled) begin
				dev = base - scaled;
				pass = dev > thr;
			end
		end else if (scaled > base) begin
			dev = scaled - base;
			pass = dev > thr;
		end
		if (pass) begin
			pk = (dev > PEAK_MAX) ? PEAK_MAX : dev;
			run_on = 1'b1;
			if (run_len != COUNT_MAX)
				run_len++;
			area_sum = sat_area(area_sum, dev);
			if (k)
				kept_sum = sat_area(kept_sum, dev);
			if (pk > peak_max) begin
				peak_max = pk;
				if (k)
					kept_peak_max = pk;
			end
		end else if (run_on && run_len > cfg_shadow.min_run) begin
			if (area_sum != 0) begin
				h.total_area = area_sum[AREA_W-1:0];
				h.total_peak = peak_max[PEAK_W-1:0];
				h.kept_area = kept_sum[AREA_W-1:0];
				h.kept_peak = kept_peak_max[PEAK_W-1:0];
				hits_due.push_back(h);
			end
			clear_run();
		end
	endfunction

	function automatic void check_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_hit();
		hit_t want;
		hits_seen++;
		if (hits_due.size() == 0) begin
			$error("unexpected hit: area %0d, peak %0d", hit_if.total_area,
				hit_if.total_peak);
			mismatches++;
		end else begin
			want = hits_due.pop_front();
			check_field("total_area", want.total_area, hit_if.total_area);
			check_field("total_peak", want.total_peak, hit_if.total_peak);
			check_field("kept_area", want.kept_area, hit_if.kept_area);
			check_field("kept_peak", want.kept_peak, hit_if.kept_peak);
		end
	endfunction

	// Range of sample codes that pass under the current registers
	function automatic bit pass_bounds(output int lo, output int hi);
		int base, thr, x;
		base = cfg_shadow.baseline;
		thr = cfg_shadow.threshold;
		thr = thr << FRAC_BITS;
		if (cfg_shadow.invert_polarity) begin
			x = base - thr;
			lo = 0;
			hi = (x - 1) >>> FRAC_BITS;
			return x > 0;
		end
		lo = ((base + thr) >> FRAC_BITS) + 1;
		hi = SAMPLE_TOP;
		return lo <= SAMPLE_TOP;
	endfunction

	// Passing sample, half the time close to the threshold
	function automatic logic [SAMPLE_W-1:0] pass_sample();
		int lo, hi, off;
		if (!pass_bounds(lo, hi))
			return SAMPLE_W'($urandom_range(SAMPLE_TOP));
		off = $urandom_range((hi - lo < 40) ? hi - lo : 40);
		if ($urandom_range(1))
			return SAMPLE_W'(cfg_shadow.invert_polarity ? hi - off : lo + off);
		return SAMPLE_W'($urandom_range(hi, lo));
	endfunction

	// Failing sample, half the time just under the threshold
	function automatic logic [SAMPLE_W-1:0] quiet_sample();
		int lo, hi, off;
		if (!pass_bounds(lo, hi))
			return SAMPLE_W'($urandom_range(SAMPLE_TOP));
		if (cfg_shadow.invert_polarity) begin
			if (hi >= SAMPLE_TOP)
				return SAMPLE_W'($urandom_range(SAMPLE_TOP));
			off = $urandom_range((SAMPLE_TOP - hi - 1 < 40) ? SAMPLE_TOP - hi - 1 : 40);
			return $urandom_range(1) ? SAMPLE_W'(hi + 1 + off) :
				SAMPLE_W'($urandom_range(SAMPLE_TOP, hi + 1));
		end
		off = $urandom_range((lo - 1 < 40) ? lo - 1 : 40);
		return $urandom_range(1) ? SAMPLE_W'(lo - 1 - off) : SAMPLE_W'($urandom_range(lo - 1));
	endfunction

	// Offer one item, wait for its handshake, then predict it
	task automatic send(logic [SAMPLE_W-1:0] s, logic k, logic f,
			chk_t how = CHK_PRED, hit_t typed = '0);
		int before_n;
		while ($urandom_range(99) < send_idle) begin
			smp_if.valid <= 1'b0;
			@(posedge clk);
		end
		smp_if.valid <= 1'b1;
		smp_if.sample <= s;
		smp_if.kept <= k;
		smp_if.first <= f;
		@(posedge clk);
		while (!smp_if.ready)
			@(posedge clk);
		samples_sent++;
		before_n = hits_due.size();
		track_run(s, k, f);
		if (how != CHK_PRED) begin
			if (hits_due.size() > before_n)
				void'(hits_due.pop_back());
			if (how == CHK_HIT)
				hits_due.push_back(typed);
		end
	endtask

	// Mostly well-formed item; now and then pure noise
	task automatic send_random(logic [SAMPLE_W-1:0] s, logic f);
		if ($urandom_range(9) == 0)
			send(SAMPLE_W'($urandom_range(SAMPLE_TOP)), 1'($urandom_range(1)),
				$urandom_range(19) == 0);
		else
			send(s, $urandom_range(99) < 70, f);
	endtask

	// Waveforms of quiet stretches and pulses sized around min_run
	task automatic run_random(int n);
		int sent, pulse_max;
		sent = 0;
		pulse_max = (cfg_shadow.min_run + 3 > 12) ? 12 : cfg_shadow.min_run + 3;
		while (sent < n) begin
			send_random(quiet_sample(), 1'b1);
			sent++;
			repeat ($urandom_range(6, 1)) begin
				repeat ($urandom_range(3)) begin
					send_random(quiet_sample(), 1'b0);
					sent++;
				end
				repeat ($urandom_range(pulse_max, 1)) begin
					send_random(pass_sample(), 1'b0);
					sent++;
				end
			end
			send_random(quiet_sample(), 1'b0);
			sent++;
		end
	endtask

	// Drop valid, wait for every hit, then let the pipeline empty
	task automatic settle();
		smp_if.valid <= 1'b0;
		while (hits_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_config(int unsigned thr, int unsigned mr, int unsigned base, bit inv);
		whf_cfg_t c;
		c.threshold = THR_W'(thr);
		c.min_run = CNT_W'(mr);
		c.baseline = BASE_W'(base);
		c.invert_polarity = inv;
		write_reg(REG_THRESHOLD, CFG_DATA_W'(c.threshold));
		write_reg(REG_MIN_RUN, CFG_DATA_W'(c.min_run));
		write_reg(REG_BASELINE, c.baseline);
		write_reg(REG_INVERT, CFG_DATA_W'(c.invert_polarity));
		cfg_we <= 1'b0;
		cfg_shadow = c;
		settings_used++;
	endtask

	// Hit receiver: check, then pick ready, with one long hold-off
	initial begin
		int stall_left;
		bit stalled_once;
		stall_left = 0;
		stalled_once = 1'b0;
		hit_if.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hit_if.valid && hit_if.ready)
				check_hit();
			if (stall_left > 0) begin
				stall_left--;
				hit_if.ready <= 1'b0;
			end else if (!stalled_once && hits_seen == 3) begin
				stalled_once = 1'b1;
				stall_left = LONG_STALL;
				hit_if.ready <= 1'b0;
			end else begin
				hit_if.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Watchdog: end the run when no item moves for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((smp_if.valid && smp_if.ready) || (hit_if.valid && hit_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		smp_if.valid <= 1'b0;
		smp_if.sample <= '0;
		smp_if.kept <= 1'b0;
		smp_if.first <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_THRESHOLD;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Slow receiver first
		send_idle = 28;
		recv_idle = 87;
		foreach (DIRECTED_ROWS[i])
			send(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].kept, DIRECTED_ROWS[i].first,
				DIRECTED_ROWS[i].how, DIRECTED_ROWS[i].want);
		settle();
		load_config(0, 0, 0, 0);
		run_random(RANDOM_ITEMS);
		settle();
		// only a zero sample passes; peak reaches full scale
		load_config(4095, 1, 65535, 1);
		run_random(RANDOM_ITEMS);
		settle();

		// Slow sender
		send_idle = 87;
		recv_idle = 28;
		load_config(100, 2, 16'h8000, 0);
		run_random(RANDOM_ITEMS);
		settle();
		load_config(200, 5, 16'h5A5A, 1);
		run_random(RANDOM_ITEMS);
		settle();

		// No idling on either side
		send_idle = 0;
		recv_idle = 0;
		repeat (2) begin
			load_config($urandom_range(600), $urandom_range(6), $urandom_range(65535),
				1'($urandom_range(1)));
			run_random(RANDOM_ITEMS);
			settle();
		end

		// One long full-scale run: the run count saturates and still exceeds min_run
		load_config(0, 254, 0, 0);
		send(12'd4095, 1'b1, 1'b1);
		repeat (SAT_RUN_LEN - 1) send(12'd4095, 1'b1, 1'b0);
		send(12'd0, 1'b0, 1'b0);
		settle();
		repeat (8) @(posedge clk);

		$display("Covered %0d samples and %0d hits over %0d register settings,",
			samples_sent, hits_seen, settings_used);
		$display("with a long output stall and a run long enough to saturate the count.");
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
